/* src/tcc_pkg.sv */
// Shared types and constants of the text console engine.
`timescale 1ns / 1ps

package tcc_pkg;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CUR_COL_W  = 6;
  localparam int unsigned CUR_ROW_W  = 5;
  localparam int unsigned CELL_W     = 2 * BYTE_W;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [BYTE_W-1:0] BLANK_CODE   = 8'd32;
  localparam logic [BYTE_W-1:0] TEXT_COLOR_RESET = 8'd14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXT_COLOR = 2'd0,
    CFG_SCROLL_EN  = 2'd1
  } cfg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT   = 2'd0,
    KIND_MOVE  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_FILL,
    ST_CLEAR,
    ST_DONE
  } state_t;

  // Status of a finished item, handed from the sequencer to the output stage.
  typedef struct packed {
    logic                 valid;
    logic [CUR_COL_W-1:0] col;
    logic [CUR_ROW_W-1:0] row;
    logic                 is_read;
    logic                 scrolled;
  } res_t;

endpackage

/* src/tcc_if.sv */
// Valid/ready channel interfaces for the console input and result words.
`timescale 1ns / 1ps

interface tcc_in_if;
  logic                        valid;
  logic                        ready;
  logic [tcc_pkg::KIND_W-1:0]  kind;
  logic [tcc_pkg::BYTE_W-1:0]  char_code;
  logic [tcc_pkg::BYTE_W-1:0]  col_pos;
  logic [tcc_pkg::BYTE_W-1:0]  row_pos;

  modport source (output valid, kind, char_code, col_pos, row_pos, input ready);
  modport sink   (input valid, kind, char_code, col_pos, row_pos, output ready);
endinterface

interface tcc_out_if;
  logic                           valid;
  logic                           ready;
  logic [tcc_pkg::CUR_COL_W-1:0]  cursor_col;
  logic [tcc_pkg::CUR_ROW_W-1:0]  cursor_row;
  logic [tcc_pkg::BYTE_W-1:0]     cell_char;
  logic [tcc_pkg::BYTE_W-1:0]     cell_color;
  logic                           did_scroll;

  modport source (output valid, cursor_col, cursor_row, cell_char, cell_color, did_scroll,
                  input ready);
  modport sink   (input valid, cursor_col, cursor_row, cell_char, cell_color, did_scroll,
                  output ready);
endinterface

/* src/text_console_cursor_scroll.sv */
// Top level of the character-cell text console engine.
//
//   channel   direction  contents
//   in_chan   sink       kind, char_code, col_pos, row_pos
//   out_chan  source     cursor_col, cursor_row, cell_char, cell_color, did_scroll
//   cfg_*     write      cfg_we, cfg_index, cfg_wdata (text_color, scroll_enable)
//
// Put, move and read go from idle straight to the done state; the cell store's single
// write port and registered read port allow this. Clear sweeps the store, one cell per cycle.
// A put that scrolls does a row-ahead copy then a blank fill of the bottom row.
// in_chan.ready is low while an item is at work; a result waiting in the output register
// does not block the next word, only its completion.
// Reset clears the cursor and the control state; the store is undefined until written.
`timescale 1ns / 1ps

module text_console_cursor_scroll #(
  parameter int unsigned SCREEN_COLS = 40,
  parameter int unsigned SCREEN_ROWS = 25
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tcc_in_if.sink                        in_chan,
  tcc_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcc_pkg::BYTE_W-1:0]    cfg_wdata
);

  localparam int unsigned CELLS  = SCREEN_COLS * SCREEN_ROWS;
  localparam int unsigned COL_W  = $clog2(SCREEN_COLS);
  localparam int unsigned ROW_W  = $clog2(SCREEN_ROWS);
  localparam int unsigned ADDR_W = $clog2(CELLS);

  logic [tcc_pkg::BYTE_W-1:0] text_color_r;
  logic                       scroll_en_r;

  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [tcc_pkg::CELL_W-1:0]  mem_wdata;
  logic                        mem_re;
  logic [ADDR_W-1:0]           mem_raddr;
  logic [tcc_pkg::CELL_W-1:0]  mem_rdata;
  tcc_pkg::res_t               res;
  logic                        out_free;

  logic                          out_valid_r;
  logic [tcc_pkg::CUR_COL_W-1:0] out_col_r;
  logic [tcc_pkg::CUR_ROW_W-1:0] out_row_r;
  logic [tcc_pkg::BYTE_W-1:0]    out_char_r;
  logic [tcc_pkg::BYTE_W-1:0]    out_color_r;
  logic                          out_scroll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= tcc_pkg::TEXT_COLOR_RESET;
      scroll_en_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        tcc_pkg::CFG_TEXT_COLOR: text_color_r <= cfg_wdata;
        tcc_pkg::CFG_SCROLL_EN:  scroll_en_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  tcc_cell_mem #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W),
    .DATA_W (tcc_pkg::CELL_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tcc_ctrl #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS),
    .COL_W       (COL_W),
    .ROW_W       (ROW_W),
    .CELLS       (CELLS),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .kind       (in_chan.kind),
    .char_code  (in_chan.char_code),
    .col_pos    (in_chan.col_pos),
    .row_pos    (in_chan.row_pos),
    .text_color (text_color_r),
    .scroll_en  (scroll_en_r),
    .out_free   (out_free),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .res        (res)
  );

  assign out_free = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res.valid;
    end
  end

  // The read word stays in the store's output register until the result is loaded.
  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      out_col_r    <= res.col;
      out_row_r    <= res.row;
      out_char_r   <= res.is_read ? mem_rdata[tcc_pkg::CELL_W-1:tcc_pkg::BYTE_W] : '0;
      out_color_r  <= res.is_read ? mem_rdata[tcc_pkg::BYTE_W-1:0] : '0;
      out_scroll_r <= res.scrolled;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.cursor_col = out_col_r;
  assign out_chan.cursor_row = out_row_r;
  assign out_chan.cell_char  = out_char_r;
  assign out_chan.cell_color = out_color_r;
  assign out_chan.did_scroll = out_scroll_r;

endmodule

/* src/tcc_cell_mem.sv */
// Cell store: one write port and one registered read port.
`timescale 1ns / 1ps

module tcc_cell_mem #(
  parameter int unsigned DEPTH  = 1000,
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/tcc_ctrl.sv */
// Sequencer: cursor, item decode and the address sweep for scroll and clear.
`timescale 1ns / 1ps

module tcc_ctrl #(
  parameter int unsigned SCREEN_COLS = 40,
  parameter int unsigned SCREEN_ROWS = 25,
  parameter int unsigned COL_W       = 6,
  parameter int unsigned ROW_W       = 5,
  parameter int unsigned CELLS       = 1000,
  parameter int unsigned ADDR_W      = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tcc_pkg::KIND_W-1:0]       kind,
  input  logic [tcc_pkg::BYTE_W-1:0]       char_code,
  input  logic [tcc_pkg::BYTE_W-1:0]       col_pos,
  input  logic [tcc_pkg::BYTE_W-1:0]       row_pos,
  input  logic [tcc_pkg::BYTE_W-1:0]       text_color,
  input  logic                             scroll_en,
  input  logic                             out_free,
  output logic                             mem_we,
  output logic [ADDR_W-1:0]                mem_waddr,
  output logic [tcc_pkg::CELL_W-1:0]       mem_wdata,
  output logic                             mem_re,
  output logic [ADDR_W-1:0]                mem_raddr,
  input  logic [tcc_pkg::CELL_W-1:0]       mem_rdata,
  output tcc_pkg::res_t                    res
);

  localparam logic [ADDR_W-1:0] COPY_END = ADDR_W'(CELLS - SCREEN_COLS);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(SCREEN_COLS);

  tcc_pkg::state_t state_r, state_nxt;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              scrolled_r, scrolled_nxt;
  logic              is_read_r, is_read_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] dst_r, dst_nxt;
  logic              pend_r, pend_nxt;

  tcc_pkg::kind_t    kind_in;
  logic              accept;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic              is_newline;
  logic              wrap;
  logic              bottom;
  logic [COL_W-1:0]  clamp_col;
  logic [ROW_W-1:0]  clamp_row;
  logic [ADDR_W-1:0] cur_idx;
  logic [ADDR_W-1:0] pos_idx;

  assign kind_in    = tcc_pkg::kind_t'(kind);
  assign accept     = (state_r == tcc_pkg::ST_IDLE) && in_valid;
  assign col_inc    = {1'b0, col_r} + (COL_W+1)'(1);
  assign row_inc    = {1'b0, row_r} + (ROW_W+1)'(1);
  assign is_newline = (char_code == tcc_pkg::NEWLINE_CODE);
  assign wrap       = is_newline || (col_inc == (COL_W+1)'(SCREEN_COLS));
  assign bottom     = (row_inc == (ROW_W+1)'(SCREEN_ROWS));
  assign clamp_col  = (col_pos >= 8'(SCREEN_COLS)) ? '0 : col_pos[COL_W-1:0];
  assign clamp_row  = (row_pos >= 8'(SCREEN_ROWS)) ? '0 : row_pos[ROW_W-1:0];
  assign cur_idx    = ADDR_W'(row_r) * ROW_STEP + ADDR_W'(col_r);
  assign pos_idx    = ADDR_W'(clamp_row) * ROW_STEP + ADDR_W'(clamp_col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcc_pkg::ST_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scrolled_r <= scrolled_nxt;
    is_read_r  <= is_read_nxt;
    cnt_r      <= cnt_nxt;
    dst_r      <= dst_nxt;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcc_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (kind_in)
            tcc_pkg::KIND_PUT: begin
              state_nxt = (wrap && bottom && scroll_en) ? tcc_pkg::ST_COPY : tcc_pkg::ST_DONE;
            end
            tcc_pkg::KIND_CLEAR: state_nxt = tcc_pkg::ST_CLEAR;
            default:             state_nxt = tcc_pkg::ST_DONE;
          endcase
        end
      end
      tcc_pkg::ST_COPY: begin
        if (cnt_r == COPY_END) state_nxt = tcc_pkg::ST_FILL;
      end
      tcc_pkg::ST_FILL, tcc_pkg::ST_CLEAR: begin
        if (cnt_r == LAST_IDX) state_nxt = tcc_pkg::ST_DONE;
      end
      tcc_pkg::ST_DONE: begin
        if (out_free) state_nxt = tcc_pkg::ST_IDLE;
      end
      default: state_nxt = tcc_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    in_ready     = (state_r == tcc_pkg::ST_IDLE);
    col_nxt      = col_r;
    row_nxt      = row_r;
    scrolled_nxt = scrolled_r;
    is_read_nxt  = is_read_r;
    cnt_nxt      = cnt_r;
    dst_nxt      = dst_r;
    pend_nxt     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = cnt_r;
    mem_wdata    = {tcc_pkg::BLANK_CODE, text_color};
    mem_re       = 1'b0;
    mem_raddr    = cnt_r + ROW_STEP;
    res          = '0;

    case (state_r)
      tcc_pkg::ST_IDLE: begin
        if (accept) begin
          scrolled_nxt = 1'b0;
          is_read_nxt  = 1'b0;
          cnt_nxt      = '0;
          case (kind_in)
            tcc_pkg::KIND_PUT: begin
              if (!is_newline) begin
                mem_we    = 1'b1;
                mem_waddr = cur_idx;
                mem_wdata = {char_code, text_color};
              end
              if (wrap) begin
                col_nxt = '0;
                if (!bottom) begin
                  row_nxt = row_inc[ROW_W-1:0];
                end else if (scroll_en) begin
                  row_nxt      = ROW_W'(SCREEN_ROWS - 1);
                  scrolled_nxt = 1'b1;
                end else begin
                  row_nxt = '0;
                end
              end else begin
                col_nxt = col_inc[COL_W-1:0];
              end
            end
            tcc_pkg::KIND_MOVE: begin
              col_nxt = clamp_col;
              row_nxt = clamp_row;
            end
            tcc_pkg::KIND_CLEAR: begin
              col_nxt = '0;
              row_nxt = '0;
            end
            default: begin
              is_read_nxt = 1'b1;
              mem_re      = 1'b1;
              mem_raddr   = pos_idx;
            end
          endcase
        end
      end
      tcc_pkg::ST_COPY: begin
        // Read one row ahead, write the word that came back on the previous cycle.
        if (cnt_r != COPY_END) begin
          mem_re   = 1'b1;
          pend_nxt = 1'b1;
          dst_nxt  = cnt_r;
          cnt_nxt  = cnt_r + ADDR_W'(1);
        end
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = dst_r;
          mem_wdata = mem_rdata;
        end
      end
      tcc_pkg::ST_FILL, tcc_pkg::ST_CLEAR: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + ADDR_W'(1);
      end
      tcc_pkg::ST_DONE: begin
        res.valid    = 1'b1;
        res.col      = tcc_pkg::CUR_COL_W'(col_r);
        res.row      = tcc_pkg::CUR_ROW_W'(row_r);
        res.is_read  = is_read_r;
        res.scrolled = scrolled_r;
      end
      default: ;
    endcase
  end

endmodule
